>>> rtl/touch_sample_filter_averager_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the touch sample filter
// Implication checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TOUCH_SAMPLE_FILTER_AVERAGER_CORE_ASSERT_SVH
`define TOUCH_SAMPLE_FILTER_AVERAGER_CORE_ASSERT_SVH

`ifndef SYNTH

`define TSFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsfa: same-cycle check failed");

`define TSFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsfa: next-cycle check failed");

`else

`define TSFA_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define TSFA_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/tsfa_pkg.sv
// ----------------------------------------------------------------------------
// tsfa_pkg
// Types and constants of the touch sample filter and averager.
// ----------------------------------------------------------------------------
package tsfa_pkg;

  localparam int unsigned DataW         = 10;
  localparam int unsigned NumSamples    = 4;
  localparam int unsigned HistDepth     = NumSamples - 1;
  localparam int unsigned CountW        = 2;
  localparam logic [DataW-1:0] DevLimitReset = DataW'(10);

  typedef enum logic [1:0] {
    CMD_PEN_CHANGE = 2'd0,
    CMD_CONV_DONE  = 2'd1,
    CMD_TIMER_TICK = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REP_NONE     = 2'd0,
    REP_RELEASE  = 2'd1,
    REP_POSITION = 2'd2
  } report_e;

  typedef enum logic [1:0] {
    ACT_WAIT_DOWN = 2'd0,
    ACT_WAIT_UP   = 2'd1,
    ACT_CONVERT   = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0]       command;
    logic             pen_up;
    logic [DataW-1:0] x_sample;
    logic [DataW-1:0] y_sample;
  } in_item_t;

  typedef struct packed {
    report_e          report;
    logic [DataW-1:0] x_position;
    logic [DataW-1:0] y_position;
    logic             touching;
    action_e          next_action;
  } out_item_t;

endpackage

>>> rtl/tsfa_seq.sv
// ----------------------------------------------------------------------------
// tsfa_seq
// Sample count, sample history, deviation filter and four-sample average.
// ----------------------------------------------------------------------------
module tsfa_seq
  import tsfa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  in_item_t         item_i,
  input  logic [DataW-1:0] limit_i,
  output out_item_t        result_o
);

  logic [CountW-1:0] count_q, count_d;
  logic [DataW-1:0]  x_hist_q [HistDepth];
  logic [DataW-1:0]  y_hist_q [HistDepth];
  logic              hist_we;
  logic              filt_ok;
  logic [DataW+1:0]  x_sum, y_sum;

  function automatic logic near_mean(input logic [DataW-1:0] a,
                                     input logic [DataW-1:0] b,
                                     input logic [DataW-1:0] s,
                                     input logic [DataW-1:0] lim);
    logic [DataW:0]   sum;
    logic [DataW-1:0] m;
    logic [DataW-1:0] d;
    sum = {1'b0, a} + {1'b0, b};
    m   = sum[DataW:1];
    d   = (s > m) ? (s - m) : (m - s);
    return d <= lim;
  endfunction

  assign filt_ok = near_mean(x_hist_q[0], x_hist_q[1], x_hist_q[2], limit_i)
                && near_mean(y_hist_q[0], y_hist_q[1], y_hist_q[2], limit_i)
                && near_mean(x_hist_q[1], x_hist_q[2], item_i.x_sample, limit_i)
                && near_mean(y_hist_q[1], y_hist_q[2], item_i.y_sample, limit_i);

  assign x_sum = {2'b00, x_hist_q[0]} + {2'b00, x_hist_q[1]}
               + {2'b00, x_hist_q[2]} + {2'b00, item_i.x_sample};
  assign y_sum = {2'b00, y_hist_q[0]} + {2'b00, y_hist_q[1]}
               + {2'b00, y_hist_q[2]} + {2'b00, item_i.y_sample};

  always_comb begin
    result_o = '{report: REP_NONE, x_position: '0, y_position: '0,
                 touching: 1'b0, next_action: ACT_WAIT_DOWN};
    count_d  = count_q;
    hist_we  = 1'b0;
    unique case (item_i.command)
      CMD_PEN_CHANGE, CMD_TIMER_TICK: begin
        if (item_i.pen_up) begin
          result_o.report = REP_RELEASE;
        end else begin
          result_o.next_action = ACT_CONVERT;
        end
      end
      CMD_CONV_DONE: begin
        if (item_i.pen_up) begin
          count_d         = '0;
          result_o.report = REP_RELEASE;
        end else if (count_q < CountW'(HistDepth)) begin
          hist_we              = 1'b1;
          count_d              = count_q + 1'b1;
          result_o.next_action = ACT_CONVERT;
        end else begin
          count_d              = '0;
          result_o.next_action = ACT_WAIT_UP;
          if (filt_ok) begin
            result_o.report     = REP_POSITION;
            result_o.x_position = x_sum[DataW+1:2];
            result_o.y_position = y_sum[DataW+1:2];
            result_o.touching   = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (step_i) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && hist_we) begin
      x_hist_q[count_q] <= item_i.x_sample;
      y_hist_q[count_q] <= item_i.y_sample;
    end
  end

endmodule

>>> rtl/touch_sample_filter_averager_core.sv
// An accepted item is held in the input register; its result is loaded into the
// output register when that register is empty or out_stall_i is low.
// Throughput: one item per cycle unless stalled; the input and output registers
// form a two-stage pipeline, and the filter and average are combinational between.
// Reset: asynchronous, active low; clears both valid flags and the sample
// count and loads the deviation limit with 10. Sample history is not reset.
// ----------------------------------------------------------------------------
// touch_sample_filter_averager_core
// Touch event sequencer with four-sample deviation filter and averager.
// ----------------------------------------------------------------------------
`include "touch_sample_filter_averager_core_assert.svh"

module touch_sample_filter_averager_core
  import tsfa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [DataW-1:0] cfg_data_i
);

  logic             in_valid_q, in_valid_d;
  in_item_t         in_item_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q;
  out_item_t        result;
  logic [DataW-1:0] limit_q;
  logic             advance;
  logic             in_accept;

  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  tsfa_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .limit_i  (limit_q),
    .result_o (result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      limit_q     <= DevLimitReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= result;
    end
  end

  `TSFA_ASSERT_IMP(a_stall_full, clk_i, rst_ni, in_stall_o, in_valid_q && out_valid_q)
  `TSFA_ASSERT_NXT(a_advance_out, clk_i, rst_ni, advance, out_valid_q)
  `TSFA_ASSERT_IMP(a_pos_fields, clk_i, rst_ni, out_valid_q && out_item_q.report == REP_POSITION, out_item_q.touching && out_item_q.next_action == ACT_WAIT_UP)
  `TSFA_ASSERT_IMP(a_release_wait, clk_i, rst_ni, out_valid_q && out_item_q.report == REP_RELEASE, !out_item_q.touching && out_item_q.next_action == ACT_WAIT_DOWN)

endmodule
